>>> design/brbp_pkg.sv
// Shared types and codes for the byte ring buffer with peek.
package brbp_pkg;

  // Operation codes
  localparam logic [2:0] FN_PUSH    = 3'd0;
  localparam logic [2:0] FN_POP     = 3'd1;
  localparam logic [2:0] FN_PEEK    = 3'd2;
  localparam logic [2:0] FN_NEWEST  = 3'd3;
  localparam logic [2:0] FN_DISCARD = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_DISCARD  = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] push_data;
    logic [8:0] peek_offset;
    logic [8:0] discard_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] status;
    logic [8:0] occupancy;
    logic [8:0] next_offset;
  } out_item_t;

  // Result held between the control unit and the output stage
  typedef struct packed {
    logic       valid;
    logic       use_mem;
    logic [2:0] status;
    logic [8:0] occupancy;
    logic [8:0] next_offset;
  } res_t;

endpackage

>>> design/byte_ring_buffer_with_peek_unit.sv
// Top level of the byte ring buffer with peek.
//
//   port group   dir  handshake          payload
//   request      in   start / busy       in_item  (in_item_t)
//   result       out  out_valid strobe   out_item (out_item_t)
//
// A request is taken on any edge with start high; busy stays low, one request per clock.
// Its result shows on out_valid in the next cycle; the result and the storage read are both registered.
// Pointers, count and strobe clear on a synchronous low rst_n; storage is not cleared.
// The receiver cannot stall; each result is valid for exactly one cycle.
module byte_ring_buffer_with_peek_unit
  import brbp_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  res_t          res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  brbp_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .res      (res)
  );

  brbp_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_valid            = res.valid;
  assign out_item.read_data   = res.use_mem ? mem_rdata : 8'd0;
  assign out_item.status      = res.status;
  assign out_item.occupancy   = res.occupancy;
  assign out_item.next_offset = res.next_offset;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without request");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.read_data == 8'd0))
    else $error("failed operation returned data");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_OVERFLOW) |-> (out_item.occupancy == 9'(DEPTH)))
    else $error("overflow reported while not full");
`endif

endmodule

>>> design/brbp_mem.sv
// Byte storage: one write port, one registered read port.
module brbp_mem
  import brbp_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/brbp_ctrl.sv
// Pointer and count control: decodes a request, drives the storage, builds the result.
module brbp_ctrl
  import brbp_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  in_item_t      item,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  output res_t          res
);

  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  res_t          res_r, res_nxt;

  logic [CW-1:0] off_w, cnt_w;
  logic [CW-1:0] peek_sum, peek_wrap, disc_sum, disc_wrap;
  logic          is_empty, is_full;
  logic [AW-1:0] wr_inc, rd_inc, newest_addr;

  assign off_w    = CW'(item.peek_offset);
  assign cnt_w    = CW'(item.discard_count);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));

  assign wr_inc = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign newest_addr = (wr_ptr_r == '0) ? AW'(DEPTH - 1) : wr_ptr_r - 1'b1;

  // offsets stay below the count on the paths that use these, so one subtract wraps
  assign peek_sum  = CW'(rd_ptr_r) + off_w;
  assign peek_wrap = (peek_sum >= CW'(DEPTH)) ? peek_sum - CW'(DEPTH) : peek_sum;
  assign disc_sum  = CW'(rd_ptr_r) + cnt_w;
  assign disc_wrap = (disc_sum >= CW'(DEPTH)) ? disc_sum - CW'(DEPTH) : disc_sum;

  always_comb begin
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_r;
    mem_wdata   = item.push_data;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_r;
    res_nxt     = '0;
    if (accept) begin
      res_nxt.valid = 1'b1;
      case (item.func)
        FN_PUSH: begin
          if (is_full) begin
            res_nxt.status = ST_OVERFLOW;
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_inc;
            count_nxt  = count_r + 1'b1;
          end
        end
        FN_POP: begin
          if (is_empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            mem_re          = 1'b1;
            res_nxt.use_mem = 1'b1;
            count_nxt       = count_r - 1'b1;
            if (count_r == CW'(1)) begin
              rd_ptr_nxt = '0;
              wr_ptr_nxt = '0;
            end else begin
              rd_ptr_nxt = rd_inc;
            end
          end
        end
        FN_PEEK: begin
          if (off_w >= count_r) begin
            res_nxt.status      = ST_RANGE;
            res_nxt.next_offset = count_r[8:0];
          end else begin
            mem_re              = 1'b1;
            mem_raddr           = peek_wrap[AW-1:0];
            res_nxt.use_mem     = 1'b1;
            res_nxt.next_offset = item.peek_offset + 9'd1;
          end
        end
        FN_NEWEST: begin
          if (is_empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            mem_re          = 1'b1;
            mem_raddr       = newest_addr;
            res_nxt.use_mem = 1'b1;
          end
        end
        FN_DISCARD: begin
          if (cnt_w > count_r) begin
            res_nxt.status = ST_DISCARD;
          end else if (cnt_w == count_r && cnt_w != '0) begin
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
            count_nxt  = '0;
          end else begin
            // a zero count lands here and changes nothing
            rd_ptr_nxt = disc_wrap[AW-1:0];
            count_nxt  = count_r - cnt_w;
          end
        end
        default: begin
        end
      endcase
      res_nxt.occupancy = count_nxt[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
      res_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> tb/byte_ring_buffer_with_peek_unit_test.sv
// Self-checking testbench: directed table plus random bursts against a shadow byte ring.
module byte_ring_buffer_with_peek_unit_test;
  import brbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Function codes the block leaves unused
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

  typedef struct {
    in_item_t  req;
    bit        fixed;
    out_item_t rsp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  byte_ring_buffer_with_peek_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the ring; 8-bit positions wrap on their own
  logic [7:0] ring_mem [0:255];
  logic [7:0] ring_rd = '0;
  logic [7:0] ring_wr = '0;
  bit         ring_empty = 1'b1;

  out_item_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int          error_total = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  function automatic logic [8:0] held_bytes();
    if (ring_empty) return 9'd0;
    if (ring_rd < ring_wr) return {1'b0, ring_wr - ring_rd};
    return 9'd256 - {1'b0, ring_rd} + {1'b0, ring_wr};
  endfunction

  task automatic clear_ring();
    ring_empty = 1'b1;
    ring_rd = '0;
    ring_wr = '0;
  endtask

  task automatic apply_request(input in_item_t req, output out_item_t rsp);
    logic [8:0] held;
    held = held_bytes();
    rsp = '0;
    rsp.status = ST_OK;
    case (req.func)
      FN_PUSH: begin
        if (!ring_empty && ring_rd == ring_wr) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          ring_mem[ring_wr] = req.push_data;
          ring_wr = ring_wr + 8'd1;
          ring_empty = 1'b0;
        end
      end
      FN_POP: begin
        if (ring_empty) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.read_data = ring_mem[ring_rd];
          ring_rd = ring_rd + 8'd1;
          if (ring_rd == ring_wr) clear_ring();
        end
      end
      FN_PEEK: begin
        if (req.peek_offset >= held) begin
          rsp.status = ST_RANGE;
          rsp.next_offset = held;
        end else begin
          rsp.read_data = ring_mem[ring_rd + req.peek_offset[7:0]];
          rsp.next_offset = req.peek_offset + 9'd1;
        end
      end
      FN_NEWEST: begin
        if (ring_empty) rsp.status = ST_EMPTY;
        else rsp.read_data = ring_mem[ring_wr - 8'd1];
      end
      FN_DISCARD: begin
        if (req.discard_count > held) begin
          rsp.status = ST_DISCARD;
        end else if (req.discard_count == held && held != 9'd0) begin
          clear_ring();
        end else begin
          ring_rd = ring_rd + req.discard_count[7:0];
        end
      end
      default: begin
      end
    endcase
    rsp.occupancy = held_bytes();
  endtask

  function automatic stim_row_t row(input logic [2:0] fn, input logic [7:0] data,
                                    input logic [8:0] off, input logic [8:0] cnt,
                                    input bit fixed, input logic [7:0] rd,
                                    input logic [2:0] st, input logic [8:0] occ,
                                    input logic [8:0] nxt);
    stim_row_t r;
    r.req.func = fn;
    r.req.push_data = data;
    r.req.peek_offset = off;
    r.req.discard_count = cnt;
    r.fixed = fixed;
    r.rsp.read_data = rd;
    r.rsp.status = st;
    r.rsp.occupancy = occ;
    r.rsp.next_offset = nxt;
    return r;
  endfunction

  function automatic in_item_t pick_request(input traffic_mode_t mode);
    in_item_t    r;
    int          held_n;
    int unsigned roll;
    int unsigned push_w;
    int unsigned pop_w;
    held_n = int'(held_bytes());
    r.func = FN_PUSH;
    r.push_data = 8'($urandom_range(0, 255));
    r.peek_offset = 9'($urandom_range(0, 511));
    r.discard_count = 9'($urandom_range(0, 511));
    // Noise: any code, any field bits
    if ($urandom_range(0, 99) < 5) begin
      r.func = 3'($urandom_range(0, 7));
      return r;
    end
    case (mode)
      MODE_FILL: begin
        push_w = 85;
        pop_w = 5;
      end
      MODE_MIX: begin
        push_w = 40;
        pop_w = 20;
      end
      default: begin
        push_w = 8;
        pop_w = 40;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_w) begin
      r.func = FN_PUSH;
    end else if (roll < push_w + pop_w) begin
      r.func = FN_POP;
    end else begin
      case ($urandom_range(0, 2))
        0: r.func = FN_PEEK;
        1: r.func = FN_NEWEST;
        default: r.func = FN_DISCARD;
      endcase
    end
    // Steer offsets and counts toward the occupancy edges
    case ($urandom_range(0, 4))
      0: r.peek_offset = 9'(held_n);
      1: r.peek_offset = 9'(held_n - 1);
      2, 3: if (held_n != 0) r.peek_offset = 9'($urandom_range(0, held_n - 1));
      default: begin
      end
    endcase
    case ($urandom_range(0, 5))
      0: r.discard_count = '0;
      1: r.discard_count = 9'(held_n);
      2: r.discard_count = 9'(held_n + 1);
      3, 4: begin
        if (held_n != 0) begin
          if (mode == MODE_DRAIN) r.discard_count = 9'($urandom_range(1, held_n));
          else r.discard_count = 9'($urandom_range(1, (held_n < 4) ? held_n : 4));
        end
      end
      default: begin
      end
    endcase
    if (held_n == 256 && $urandom_range(0, 9) == 0) begin
      r.func = FN_DISCARD;
      r.discard_count = '0;
    end
    return r;
  endfunction

  // Drop start between bursts; a zero gap merges two bursts
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_request(input in_item_t req, input bit fixed, input out_item_t typed);
    out_item_t rsp;
    start <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(req, rsp);
    pending_results.push_back(fixed ? typed : rsp);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: %h", out_item);
        error_total++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $error("read_data expected %0h got %0h", want.read_data, out_item.read_data);
          error_total++;
        end
        if (out_item.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_item.status);
          error_total++;
        end
        if (out_item.occupancy !== want.occupancy) begin
          $error("occupancy expected %0d got %0d", want.occupancy, out_item.occupancy);
          error_total++;
        end
        if (out_item.next_offset !== want.next_offset) begin
          $error("next_offset expected %0d got %0d", want.next_offset, out_item.next_offset);
          error_total++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("byte_ring_buffer_with_peek_unit_test: errors");
      $finish;
    end
  end

  initial begin
    traffic_mode_t mode;
    int unsigned   sent;
    int unsigned   seg_count;
    int unsigned   past_goal;
    int unsigned   tail;
    bit            goal;

    //                      func         data   offset  count   fix rdata  status       occ  next
    directed_rows.push_back(row(FN_POP,     8'h00, 9'd0,   9'd0,   1, 8'h00, ST_EMPTY,    0, 0));
    directed_rows.push_back(row(FN_NEWEST,  8'h00, 9'd0,   9'd0,   1, 8'h00, ST_EMPTY,    0, 0));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'd0,   9'd0,   1, 8'h00, ST_RANGE,    0, 0));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'h1FF, 9'd0,   1, 8'h00, ST_RANGE,    0, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd1,   1, 8'h00, ST_DISCARD,  0, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'h1FF, 1, 8'h00, ST_DISCARD,  0, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd0,   1, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_SPARE_LO, 8'h00, 9'd0,  9'd0,   1, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_SPARE_HI, 8'hFF, 9'h1FF, 9'h1FF, 1, 8'h00, ST_OK,      0, 0));
    directed_rows.push_back(row(FN_PUSH,    8'hFF, 9'd0,   9'd0,   1, 8'h00, ST_OK,       1, 0));
    directed_rows.push_back(row(FN_PUSH,    8'h00, 9'h1FF, 9'h1FF, 1, 8'h00, ST_OK,       2, 0));
    directed_rows.push_back(row(FN_NEWEST,  8'h00, 9'd0,   9'd0,   1, 8'h00, ST_OK,       2, 0));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'd0,   9'd0,   1, 8'hFF, ST_OK,       2, 1));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'd1,   9'd0,   1, 8'h00, ST_OK,       2, 2));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'd2,   9'd0,   1, 8'h00, ST_RANGE,    2, 2));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd0,   1, 8'h00, ST_OK,       2, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd3,   1, 8'h00, ST_DISCARD,  2, 0));
    directed_rows.push_back(row(FN_POP,     8'h00, 9'd0,   9'd0,   1, 8'hFF, ST_OK,       1, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd1,   1, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_PUSH,    8'hA5, 9'd0,   9'd0,   0, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_PUSH,    8'h5A, 9'd0,   9'd0,   0, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_PEEK,    8'h00, 9'd1,   9'd0,   0, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_DISCARD, 8'h00, 9'd0,   9'd2,   0, 8'h00, ST_OK,       0, 0));
    directed_rows.push_back(row(FN_PUSH,    8'h3C, 9'd0,   9'd0,   1, 8'h00, ST_OK,       1, 0));
    directed_rows.push_back(row(FN_POP,     8'h00, 9'd0,   9'd0,   1, 8'h3C, ST_OK,       0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      pace();
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
    end

    // Cycle fill, mix and drain so the ring reaches full and empty repeatedly
    sent = 0;
    mode = MODE_FILL;
    while (sent < RANDOM_ITEMS) begin
      seg_count = 0;
      past_goal = 0;
      case (mode)
        MODE_FILL: tail = 40;
        MODE_MIX: tail = 150;
        default: tail = 15;
      endcase
      while (sent < RANDOM_ITEMS && past_goal < tail && seg_count < 500) begin
        pace();
        send_request(pick_request(mode), 1'b0, '0);
        sent++;
        seg_count++;
        case (mode)
          MODE_FILL: goal = (held_bytes() == 9'd256) || past_goal != 0;
          MODE_DRAIN: goal = (held_bytes() == 9'd0) || past_goal != 0;
          default: goal = 1'b1;
        endcase
        if (goal) past_goal++;
      end
      case (mode)
        MODE_FILL: mode = MODE_MIX;
        MODE_MIX: mode = MODE_DRAIN;
        default: mode = MODE_FILL;
      endcase
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0) begin
      $display("byte_ring_buffer_with_peek_unit_test: clean");
    end else begin
      $display("byte_ring_buffer_with_peek_unit_test: errors");
    end
    $finish;
  end

endmodule
